FILE: rtl/fra_pkg.sv
// Shared types and constants for the frame run allocator.
`timescale 1ns / 1ps

package fra_pkg;

   localparam int CMD_W      = 2;
   localparam int BYTE_W     = 40;
   localparam int SUM_W      = 41;
   localparam int REGION_W   = 3;
   localparam int FIRST_W    = 6;
   localparam int RUN_W      = 7;
   localparam int STATUS_W   = 2;
   localparam int FRAMES_W   = 10;
   localparam int COUNT_W    = 32;
   localparam int SHIFT_W    = 5;
   localparam int LIMIT_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam int LEVEL_W    = 3;
   localparam int SPAN_W     = 8;
   localparam int CHUNK_W    = 8;
   localparam int PCNT_W     = 4;

   localparam logic [SHIFT_W-1:0] FRAME_SHIFT_RESET  = 5'd20;
   localparam logic [LIMIT_W-1:0] REGION_LIMIT_RESET = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_SHIFT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_LIMIT = 1'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_DIRECT  = 2'd2,
      CMD_COPIED  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_ZERO      = 2'd1,
      ST_EXHAUSTED = 2'd2
   } status_type;

endpackage

FILE: rtl/frame_run_allocator_core.sv
// Counting commands go straight to the result; a release reads the row, clears the run, then counts
// freed frames eight at a time. Alloc: sizes the request, then reads one bitmap row per region scanned.
// One transfer at a time; the next request is taken when the sequencer is idle.
// A stalled result holds the sequencer; the window unit and bitmap memory serve one command at a time.
// Reset is synchronous; per-row valid flags make every bitmap read as free, with no clearing pass.
`timescale 1ns / 1ps

module frame_run_allocator_core
   import fra_pkg::*;
#(
   parameter int MAX_REGIONS       = 8,
   parameter int FRAMES_PER_REGION = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [BYTE_W-1:0]     req_byte_count,
   input  logic [REGION_W-1:0]   req_region_index,
   input  logic [FIRST_W-1:0]    req_first_frame,
   input  logic [RUN_W-1:0]      req_run_frames,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [REGION_W-1:0]   rsp_granted_region,
   output logic [FIRST_W-1:0]    rsp_granted_first,
   output logic [RUN_W-1:0]      rsp_granted_frames,
   output logic [FRAMES_W-1:0]   rsp_free_frames,
   output logic [FRAMES_W-1:0]   rsp_total_frames,
   output logic [COUNT_W-1:0]    rsp_allocated_count,
   output logic [COUNT_W-1:0]    rsp_exhausted_count,
   output logic [COUNT_W-1:0]    rsp_grown_count,
   output logic [COUNT_W-1:0]    rsp_direct_count,
   output logic [COUNT_W-1:0]    rsp_copied_count,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int FPR = FRAMES_PER_REGION;
   localparam int RW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CW  = $clog2(MAX_REGIONS + 1);
   localparam int FW  = (FPR > 1) ? $clog2(FPR) : 1;
   localparam int TW  = $clog2(MAX_REGIONS * FPR + 1);
   localparam int NCH = (FPR + CHUNK_W - 1) / CHUNK_W;
   localparam int CCW = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int NLV = 2 ** LEVEL_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_NEED,
      S_SCAN_RD,
      S_SCAN_CP,
      S_SCAN_WIN,
      S_GRANT,
      S_REL_RD,
      S_REL_CLR,
      S_REL_CNT,
      S_FINISH
   } state_type;

   // Control state.
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SHIFT_W-1:0]    shift_ff, shift_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [CW-1:0]         regions_ff, regions_in;
   logic [TW-1:0]         total_ff, total_in;
   logic [TW-1:0]         free_ff, free_in;
   logic [MAX_REGIONS-1:0] row_valid_ff, row_valid_in;
   logic [COUNT_W-1:0]    alloc_cnt_ff, alloc_cnt_in;
   logic [COUNT_W-1:0]    exh_cnt_ff, exh_cnt_in;
   logic [COUNT_W-1:0]    grow_cnt_ff, grow_cnt_in;
   logic [COUNT_W-1:0]    direct_cnt_ff, direct_cnt_in;
   logic [COUNT_W-1:0]    copied_cnt_ff, copied_cnt_in;

   // Working registers.
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  zero_ff, zero_in;
   logic [RUN_W-1:0]      frames_ff, frames_in;
   logic [LEVEL_W-1:0]    lvl_ff, lvl_in;
   logic [RUN_W-1:0]      rem_ff, rem_in;
   logic [RW-1:0]         region_ff, region_in;
   logic [RW-1:0]         addr_ff, addr_in;
   logic [FPR-1:0]        cp_ff, cp_in;
   logic [FPR-1:0]        word_ff, word_in;
   logic [FW-1:0]         first_ff, first_in;
   logic [FIRST_W-1:0]    rel_first_ff, rel_first_in;
   logic [RUN_W-1:0]      rel_run_ff, rel_run_in;
   logic                  rel_ok_ff, rel_ok_in;
   logic [NCH*CHUNK_W-1:0] cnt_word_ff, cnt_word_in;
   logic [CCW-1:0]        chunk_ff, chunk_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [REGION_W-1:0]   greg_ff, greg_in;
   logic [FIRST_W-1:0]    gfirst_ff, gfirst_in;
   logic [RUN_W-1:0]      gframes_ff, gframes_in;
   logic                  rd_valid_ff;

   // Result register.
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [REGION_W-1:0]   rsp_region_ff, rsp_region_in;
   logic [FIRST_W-1:0]    rsp_first_ff, rsp_first_in;
   logic [RUN_W-1:0]      rsp_frames_ff, rsp_frames_in;
   logic [FRAMES_W-1:0]   rsp_free_ff, rsp_free_in;
   logic [FRAMES_W-1:0]   rsp_total_ff, rsp_total_in;
   logic [COUNT_W-1:0]    rsp_alloc_ff, rsp_alloc_in;
   logic [COUNT_W-1:0]    rsp_exh_ff, rsp_exh_in;
   logic [COUNT_W-1:0]    rsp_grow_ff, rsp_grow_in;
   logic [COUNT_W-1:0]    rsp_direct_ff, rsp_direct_in;
   logic [COUNT_W-1:0]    rsp_copied_ff, rsp_copied_in;

   // Bitmap memory.
   logic [FPR-1:0]        map_mem [MAX_REGIONS];
   logic [FPR-1:0]        rd_word_ff;
   logic                  mem_we;
   logic [RW-1:0]         mem_waddr;
   logic [FPR-1:0]        mem_wdata;

   // Shared window unit and helpers.
   logic [FPR-1:0]        free_word;
   logic [FPR-1:0]        cur_word;
   logic [FPR-1:0]        lv [NLV];
   logic [FPR-1:0]        win;
   logic                  win_found;
   logic [FW-1:0]         win_idx;
   logic [SPAN_W-1:0]     grant_end;
   logic [FPR-1:0]        grant_mask;
   logic [SPAN_W-1:0]     rel_end;
   logic [FPR-1:0]        rel_mask;
   logic [FPR-1:0]        rel_clr;
   logic [SUM_W-1:0]      need;
   logic [PCNT_W-1:0]     pcnt;
   logic                  grow_ok;
   logic                  more_regions;
   logic                  accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign free_word = rd_valid_ff ? ~rd_word_ff : {FPR{1'b1}};
   assign cur_word  = rd_valid_ff ? rd_word_ff : {FPR{1'b0}};
   assign need      = sum_ff >> shift_ff;
   assign win       = cp_ff & (cp_ff >> rem_ff);
   assign grant_end = SPAN_W'(first_ff) + SPAN_W'(frames_ff);
   assign rel_end   = SPAN_W'(rel_first_ff) + SPAN_W'(rel_run_ff);
   assign rel_clr   = cur_word & rel_mask & {FPR{rel_ok_ff}};
   assign grow_ok   = (SPAN_W'(regions_ff) < SPAN_W'(limit_ff))
                      && (SPAN_W'(regions_ff) < SPAN_W'(MAX_REGIONS));
   assign more_regions = (CW'(region_ff) + CW'(1)) < regions_ff;

   always_comb begin
      lv[0] = free_word;
      for (int k = 1; k < NLV; k++) begin
         lv[k] = lv[k-1] & (lv[k-1] >> (1 << (k - 1)));
      end
   end

   always_comb begin
      win_found = |win;
      win_idx   = '0;
      for (int i = FPR - 1; i >= 0; i--) begin
         if (win[i]) begin
            win_idx = FW'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < FPR; i++) begin
         grant_mask[i] = (SPAN_W'(i) >= SPAN_W'(first_ff)) && (SPAN_W'(i) < grant_end);
         rel_mask[i]   = (SPAN_W'(i) >= SPAN_W'(rel_first_ff)) && (SPAN_W'(i) < rel_end);
      end
   end

   always_comb begin
      pcnt = '0;
      for (int k = 0; k < CHUNK_W; k++) begin
         pcnt = pcnt + PCNT_W'(cnt_word_ff[k]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      shift_in      = shift_ff;
      limit_in      = limit_ff;
      regions_in    = regions_ff;
      total_in      = total_ff;
      free_in       = free_ff;
      row_valid_in  = row_valid_ff;
      alloc_cnt_in  = alloc_cnt_ff;
      exh_cnt_in    = exh_cnt_ff;
      grow_cnt_in   = grow_cnt_ff;
      direct_cnt_in = direct_cnt_ff;
      copied_cnt_in = copied_cnt_ff;
      sum_in        = sum_ff;
      zero_in       = zero_ff;
      frames_in     = frames_ff;
      lvl_in        = lvl_ff;
      rem_in        = rem_ff;
      region_in     = region_ff;
      addr_in       = addr_ff;
      cp_in         = cp_ff;
      word_in       = word_ff;
      first_in      = first_ff;
      rel_first_in  = rel_first_ff;
      rel_run_in    = rel_run_ff;
      rel_ok_in     = rel_ok_ff;
      cnt_word_in   = cnt_word_ff;
      chunk_in      = chunk_ff;
      status_in     = status_ff;
      greg_in       = greg_ff;
      gfirst_in     = gfirst_ff;
      gframes_in    = gframes_ff;
      rsp_status_in = rsp_status_ff;
      rsp_region_in = rsp_region_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_frames_in = rsp_frames_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_alloc_in  = rsp_alloc_ff;
      rsp_exh_in    = rsp_exh_ff;
      rsp_grow_in   = rsp_grow_ff;
      rsp_direct_in = rsp_direct_ff;
      rsp_copied_in = rsp_copied_ff;
      mem_we        = 1'b0;
      mem_waddr     = region_ff;
      mem_wdata     = word_ff | grant_mask;

      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_SHIFT:  shift_in = csr_wdata;
            CSR_REGION_LIMIT: limit_in = csr_wdata[LIMIT_W-1:0];
            default:          ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in    = ST_OK;
               greg_in      = '0;
               gfirst_in    = '0;
               gframes_in   = '0;
               zero_in      = (req_byte_count == '0);
               sum_in       = SUM_W'(req_byte_count)
                              + ((SUM_W'(1) << shift_ff) - SUM_W'(1));
               region_in    = RW'(req_region_index);
               addr_in      = RW'(req_region_index);
               rel_first_in = req_first_frame;
               rel_run_in   = req_run_frames;
               rel_ok_in    = SPAN_W'(req_region_index) < SPAN_W'(regions_ff);
               unique case (cmd_type'(req_command))
                  CMD_ALLOC:   state_in = S_NEED;
                  CMD_RELEASE: state_in = S_REL_RD;
                  CMD_DIRECT: begin
                     direct_cnt_in = direct_cnt_ff + COUNT_W'(1);
                     state_in      = S_FINISH;
                  end
                  CMD_COPIED: begin
                     copied_cnt_in = copied_cnt_ff + COUNT_W'(1);
                     state_in      = S_FINISH;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_NEED: begin
            frames_in = need[RUN_W-1:0];
            lvl_in    = '0;
            for (int i = 0; i < RUN_W; i++) begin
               if (need[i]) begin
                  lvl_in = LEVEL_W'(i);
               end
            end
            rem_in    = need[RUN_W-1:0] - (RUN_W'(1) << lvl_in);
            region_in = '0;
            addr_in   = '0;
            if (zero_ff) begin
               status_in = ST_ZERO;
               state_in  = S_FINISH;
            end else if (need > SUM_W'(FPR)) begin
               status_in  = ST_EXHAUSTED;
               exh_cnt_in = exh_cnt_ff + COUNT_W'(1);
               state_in   = S_FINISH;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CP;
         end
         S_SCAN_CP: begin
            cp_in    = lv[lvl_ff];
            word_in  = cur_word;
            addr_in  = region_ff + RW'(1);
            state_in = S_SCAN_WIN;
         end
         S_SCAN_WIN: begin
            if (win_found) begin
               first_in = win_idx;
               state_in = S_GRANT;
            end else if (more_regions) begin
               region_in = region_ff + RW'(1);
               state_in  = S_SCAN_CP;
            end else if (grow_ok) begin
               region_in   = RW'(regions_ff);
               regions_in  = regions_ff + CW'(1);
               grow_cnt_in = grow_cnt_ff + COUNT_W'(1);
               total_in    = total_ff + TW'(FPR);
               free_in     = free_ff + TW'(FPR);
               word_in     = '0;
               first_in    = '0;
               state_in    = S_GRANT;
            end else begin
               status_in  = ST_EXHAUSTED;
               exh_cnt_in = exh_cnt_ff + COUNT_W'(1);
               state_in   = S_FINISH;
            end
         end
         S_GRANT: begin
            mem_we                  = 1'b1;
            row_valid_in[region_ff] = 1'b1;
            alloc_cnt_in            = alloc_cnt_ff + COUNT_W'(1);
            free_in                 = free_ff - TW'(frames_ff);
            status_in               = ST_OK;
            greg_in                 = REGION_W'(region_ff);
            gfirst_in               = FIRST_W'(first_ff);
            gframes_in              = frames_ff;
            state_in                = S_FINISH;
         end
         S_REL_RD: begin
            state_in = S_REL_CLR;
         end
         S_REL_CLR: begin
            mem_we      = rel_ok_ff;
            mem_wdata   = cur_word & ~rel_clr;
            if (rel_ok_ff) begin
               row_valid_in[region_ff] = 1'b1;
            end
            cnt_word_in = (NCH * CHUNK_W)'(rel_clr);
            chunk_in    = '0;
            state_in    = S_REL_CNT;
         end
         S_REL_CNT: begin
            free_in     = free_ff + TW'(pcnt);
            cnt_word_in = cnt_word_ff >> CHUNK_W;
            chunk_in    = chunk_ff + CCW'(1);
            if (chunk_ff == CCW'(NCH - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_region_in = greg_ff;
               rsp_first_in  = gfirst_ff;
               rsp_frames_in = gframes_ff;
               rsp_free_in   = FRAMES_W'(free_ff);
               rsp_total_in  = FRAMES_W'(total_ff);
               rsp_alloc_in  = alloc_cnt_ff;
               rsp_exh_in    = exh_cnt_ff;
               rsp_grow_in   = grow_cnt_ff;
               rsp_direct_in = direct_cnt_ff;
               rsp_copied_in = copied_cnt_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         shift_ff      <= FRAME_SHIFT_RESET;
         limit_ff      <= REGION_LIMIT_RESET;
         regions_ff    <= CW'(1);
         total_ff      <= TW'(FPR);
         free_ff       <= TW'(FPR);
         row_valid_ff  <= '0;
         alloc_cnt_ff  <= '0;
         exh_cnt_ff    <= '0;
         grow_cnt_ff   <= COUNT_W'(1);
         direct_cnt_ff <= '0;
         copied_cnt_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         shift_ff      <= shift_in;
         limit_ff      <= limit_in;
         regions_ff    <= regions_in;
         total_ff      <= total_in;
         free_ff       <= free_in;
         row_valid_ff  <= row_valid_in;
         alloc_cnt_ff  <= alloc_cnt_in;
         exh_cnt_ff    <= exh_cnt_in;
         grow_cnt_ff   <= grow_cnt_in;
         direct_cnt_ff <= direct_cnt_in;
         copied_cnt_ff <= copied_cnt_in;
      end
      sum_ff        <= sum_in;
      zero_ff       <= zero_in;
      frames_ff     <= frames_in;
      lvl_ff        <= lvl_in;
      rem_ff        <= rem_in;
      region_ff     <= region_in;
      addr_ff       <= addr_in;
      cp_ff         <= cp_in;
      word_ff       <= word_in;
      first_ff      <= first_in;
      rel_first_ff  <= rel_first_in;
      rel_run_ff    <= rel_run_in;
      rel_ok_ff     <= rel_ok_in;
      cnt_word_ff   <= cnt_word_in;
      chunk_ff      <= chunk_in;
      status_ff     <= status_in;
      greg_ff       <= greg_in;
      gfirst_ff     <= gfirst_in;
      gframes_ff    <= gframes_in;
      rd_valid_ff   <= row_valid_ff[addr_ff];
      rsp_status_ff <= rsp_status_in;
      rsp_region_ff <= rsp_region_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_frames_ff <= rsp_frames_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_alloc_ff  <= rsp_alloc_in;
      rsp_exh_ff    <= rsp_exh_in;
      rsp_grow_ff   <= rsp_grow_in;
      rsp_direct_ff <= rsp_direct_in;
      rsp_copied_ff <= rsp_copied_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_word_ff <= map_mem[addr_ff];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_region  = rsp_region_ff;
   assign rsp_granted_first   = rsp_first_ff;
   assign rsp_granted_frames  = rsp_frames_ff;
   assign rsp_free_frames     = rsp_free_ff;
   assign rsp_total_frames    = rsp_total_ff;
   assign rsp_allocated_count = rsp_alloc_ff;
   assign rsp_exhausted_count = rsp_exh_ff;
   assign rsp_grown_count     = rsp_grow_ff;
   assign rsp_direct_count    = rsp_direct_ff;
   assign rsp_copied_count    = rsp_copied_ff;

endmodule

FILE: rtl/fra_checker.sv
// Port-level assertions for the frame run allocator, bound to the allocator core.
`timescale 1ns / 1ps

module fra_checker
   import fra_pkg::*;
#(
   parameter int FRAMES_PER_REGION = 64
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [FIRST_W-1:0]  rsp_granted_first,
   input logic [RUN_W-1:0]    rsp_granted_frames
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one still in work");

   a_failure_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK)
      |-> (rsp_granted_frames == '0 && rsp_granted_first == '0))
      else $error("failed request reports a grant");

   a_grant_in_region: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK && rsp_granted_frames != '0)
      |-> ((SPAN_W'(rsp_granted_first) + SPAN_W'(rsp_granted_frames))
           <= SPAN_W'(FRAMES_PER_REGION)))
      else $error("granted run crosses the region end");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_granted_first)))
      else $error("stalled result changed");

endmodule

bind frame_run_allocator_core fra_checker #(
   .FRAMES_PER_REGION(FRAMES_PER_REGION)
) u_fra_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_granted_first  (rsp_granted_first),
   .rsp_granted_frames (rsp_granted_frames)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the frame run allocator core, with a scoreboard class.
`timescale 1ns / 1ps

import fra_pkg::*;

typedef struct packed {
   status_type          status;
   logic [REGION_W-1:0] region;
   logic [FIRST_W-1:0]  first;
   logic [RUN_W-1:0]    frames;
   logic [FRAMES_W-1:0] free_frames;
   logic [FRAMES_W-1:0] total_frames;
   logic [COUNT_W-1:0]  allocated;
   logic [COUNT_W-1:0]  exhausted;
   logic [COUNT_W-1:0]  grown;
   logic [COUNT_W-1:0]  direct;
   logic [COUNT_W-1:0]  copied;
} alloc_result_t;

typedef struct {
   int region;
   int first;
   int frames;
} live_run_t;

class run_ledger;
   localparam int REGIONS       = 8;
   localparam int REGION_FRAMES = 64;
   localparam int MAX_REPORTS   = 10;

   logic [REGION_FRAMES-1:0] taken [REGIONS];
   int unsigned   used [REGIONS];
   int unsigned   regions;
   logic [31:0]   n_alloc;
   logic [31:0]   n_exhaust;
   logic [31:0]   n_grow;
   logic [31:0]   n_direct;
   logic [31:0]   n_copied;
   int unsigned   shift;
   int unsigned   limit;
   alloc_result_t awaited_results [$];
   live_run_t     live [$];
   int unsigned   mismatches;
   int unsigned   checked;
   int unsigned   seen_zero;
   int unsigned   seen_release;

   function new();
      for (int r = 0; r < REGIONS; r++) begin
         taken[r] = '0;
         used[r]  = 0;
      end
      regions      = 1;
      n_alloc      = '0;
      n_exhaust    = '0;
      n_grow       = 32'd1;
      n_direct     = '0;
      n_copied     = '0;
      shift        = 20;
      limit        = 8;
      mismatches   = 0;
      checked      = 0;
      seen_zero    = 0;
      seen_release = 0;
   endfunction

   function void set_config(int unsigned new_shift, int unsigned new_limit);
      shift = new_shift & 31;
      limit = new_limit & 15;
   endfunction

   function int unsigned pending();
      return awaited_results.size();
   endfunction

   function bit find_run(int unsigned frames, output int unsigned region,
                         output int unsigned first);
      int unsigned run_len;
      region = 0;
      first  = 0;
      for (int unsigned r = 0; r < regions && r < REGIONS; r++) begin
         if (frames > REGION_FRAMES - used[r]) continue;
         run_len = 0;
         for (int unsigned i = 0; i < REGION_FRAMES; i++) begin
            run_len = taken[r][i] ? 0 : run_len + 1;
            if (run_len >= frames) begin
               first = i + 1 - frames;
               for (int unsigned j = first; j <= i; j++) taken[r][j] = 1'b1;
               used[r] += frames;
               n_alloc++;
               region = r;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function void book_request(cmd_type cmd, logic [BYTE_W-1:0] bytes,
                              logic [REGION_W-1:0] rix, logic [FIRST_W-1:0] ff,
                              logic [RUN_W-1:0] rf);
      alloc_result_t want;
      logic [63:0]   mask;
      logic [63:0]   need;
      int unsigned   frames;
      int unsigned   g_region;
      int unsigned   g_first;
      int unsigned   lim;
      int unsigned   total;
      int unsigned   in_use;
      int            lo;
      int            hi;
      bit            ok;
      want        = '0;
      want.status = ST_OK;
      case (cmd)
         CMD_ALLOC: begin
            if (bytes == '0) begin
               want.status = ST_ZERO;
               seen_zero++;
            end else begin
               mask = (64'd1 << shift) - 64'd1;
               need = ({24'd0, bytes} + mask) >> shift;
               if (need > REGION_FRAMES) begin
                  n_exhaust++;
                  want.status = ST_EXHAUSTED;
               end else begin
                  frames = need;
                  ok = find_run(frames, g_region, g_first);
                  if (!ok) begin
                     lim = (limit < REGIONS) ? limit : REGIONS;
                     if (regions < lim) begin
                        taken[regions] = '0;
                        used[regions]  = 0;
                        regions++;
                        n_grow++;
                        ok = find_run(frames, g_region, g_first);
                     end
                  end
                  if (ok) begin
                     want.region = REGION_W'(g_region);
                     want.first  = FIRST_W'(g_first);
                     want.frames = RUN_W'(frames);
                     live.push_back('{g_region, g_first, frames});
                  end else begin
                     n_exhaust++;
                     want.status = ST_EXHAUSTED;
                  end
               end
            end
         end
         CMD_RELEASE: begin
            seen_release++;
            if (rix < regions) begin
               lo = ff;
               hi = (int'(ff) + int'(rf) < REGION_FRAMES) ? int'(ff) + int'(rf) : REGION_FRAMES;
               for (int i = lo; i < hi; i++) begin
                  if (taken[rix][i]) begin
                     taken[rix][i] = 1'b0;
                     if (used[rix] > 0) used[rix]--;
                  end
               end
               for (int k = live.size() - 1; k >= 0; k--) begin
                  if (live[k].region == rix && live[k].first < hi &&
                      live[k].first + live[k].frames > lo)
                     live.delete(k);
               end
            end
         end
         CMD_DIRECT: n_direct++;
         default:    n_copied++;
      endcase
      total  = 0;
      in_use = 0;
      for (int r = 0; r < regions && r < REGIONS; r++) begin
         total  += REGION_FRAMES;
         in_use += used[r];
      end
      want.free_frames  = FRAMES_W'(total - in_use);
      want.total_frames = FRAMES_W'(total);
      want.allocated    = n_alloc;
      want.exhausted    = n_exhaust;
      want.grown        = n_grow;
      want.direct       = n_direct;
      want.copied       = n_copied;
      awaited_results.push_back(want);
   endfunction

   function string show(alloc_result_t r);
      return $sformatf({"status=%0d region=%0d first=%0d frames=%0d free=%0d total=%0d",
                        " alloc=%0d exhaust=%0d grown=%0d direct=%0d copied=%0d"},
                       r.status, r.region, r.first, r.frames, r.free_frames,
                       r.total_frames, r.allocated, r.exhausted, r.grown, r.direct,
                       r.copied);
   endfunction

   function void check_response(alloc_result_t got);
      alloc_result_t want;
      checked++;
      if (awaited_results.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("ERROR: result %0d arrived with no request outstanding: %s",
                     checked, show(got));
         return;
      end
      want = awaited_results.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: result %0d differs", checked);
            $display("   expected %s", show(want));
            $display("   actual   %s", show(got));
         end
      end
   endfunction
endclass

module tb_top;
   import fra_pkg::*;

   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int PHASE_ITEMS    = 120;
   localparam int LAST_ITEMS     = 110;
   localparam int NUM_PHASES     = 6;
   localparam int unsigned PHASE_SHIFT [NUM_PHASES] = '{0, 6, 31, 12, 3, 1};
   localparam int unsigned PHASE_LIMIT [NUM_PHASES] = '{1, 3, 0, 15, 8, 2};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command = '0;
   logic [BYTE_W-1:0]     req_byte_count = '0;
   logic [REGION_W-1:0]   req_region_index = '0;
   logic [FIRST_W-1:0]    req_first_frame = '0;
   logic [RUN_W-1:0]      req_run_frames = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [REGION_W-1:0]   rsp_granted_region;
   logic [FIRST_W-1:0]    rsp_granted_first;
   logic [RUN_W-1:0]      rsp_granted_frames;
   logic [FRAMES_W-1:0]   rsp_free_frames;
   logic [FRAMES_W-1:0]   rsp_total_frames;
   logic [COUNT_W-1:0]    rsp_allocated_count;
   logic [COUNT_W-1:0]    rsp_exhausted_count;
   logic [COUNT_W-1:0]    rsp_grown_count;
   logic [COUNT_W-1:0]    rsp_direct_count;
   logic [COUNT_W-1:0]    rsp_copied_count;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   run_ledger   ledger;
   bit          hold_rsp = 1'b0;
   bit          idle_on = 1'b1;
   int unsigned sent = 0;
   int unsigned settings = 0;

   frame_run_allocator_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_byte_count     (req_byte_count),
      .req_region_index   (req_region_index),
      .req_first_frame    (req_first_frame),
      .req_run_frames     (req_run_frames),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_granted_region (rsp_granted_region),
      .rsp_granted_first  (rsp_granted_first),
      .rsp_granted_frames (rsp_granted_frames),
      .rsp_free_frames    (rsp_free_frames),
      .rsp_total_frames   (rsp_total_frames),
      .rsp_allocated_count(rsp_allocated_count),
      .rsp_exhausted_count(rsp_exhausted_count),
      .rsp_grown_count    (rsp_grown_count),
      .rsp_direct_count   (rsp_direct_count),
      .rsp_copied_count   (rsp_copied_count),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [BYTE_W-1:0] bytes_for(int unsigned frames, int unsigned shift);
      logic [63:0] base;
      logic [63:0] slack;
      base  = 64'(frames - 1) << shift;
      slack = {$urandom, $urandom} & ((64'd1 << shift) - 64'd1);
      return BYTE_W'(base + slack + 64'd1);
   endfunction

   task automatic send_item(cmd_type cmd, logic [BYTE_W-1:0] bytes,
                            logic [REGION_W-1:0] rix, logic [FIRST_W-1:0] ff,
                            logic [RUN_W-1:0] rf);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_byte_count   <= bytes;
      req_region_index <= rix;
      req_first_frame  <= ff;
      req_run_frames   <= rf;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.book_request(cmd, bytes, rix, ff, rf);
      sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(int unsigned shift, int unsigned limit);
      csr_write <= 1'b1;
      csr_index <= CSR_FRAME_SHIFT;
      csr_wdata <= CSR_DATA_W'(shift);
      @(posedge clock);
      csr_index <= CSR_REGION_LIMIT;
      csr_wdata <= CSR_DATA_W'(limit);
      @(posedge clock);
      csr_write <= 1'b0;
      ledger.set_config(shift, limit);
      settings++;
   endtask

   task automatic random_item();
      int unsigned pick;
      int unsigned frames;
      int unsigned k;
      live_run_t   run;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         frames = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
         send_item(CMD_ALLOC, bytes_for(frames, ledger.shift), REGION_W'($urandom),
                   FIRST_W'($urandom), RUN_W'($urandom));
      end else if (pick < 75 && ledger.live.size() > 0) begin
         k   = $urandom_range(0, ledger.live.size() - 1);
         run = ledger.live[k];
         send_item(CMD_RELEASE, BYTE_W'({$urandom, $urandom}), REGION_W'(run.region),
                   FIRST_W'(run.first), RUN_W'(run.frames));
      end else if (pick < 85) begin
         send_item(($urandom_range(0, 1) == 1) ? CMD_DIRECT : CMD_COPIED,
                   BYTE_W'({$urandom, $urandom}), REGION_W'($urandom),
                   FIRST_W'($urandom), RUN_W'($urandom));
      end else begin
         case ($urandom_range(0, 3))
            0: send_item(CMD_ALLOC, BYTE_W'({$urandom, $urandom}), REGION_W'($urandom),
                         FIRST_W'($urandom), RUN_W'($urandom));
            1: send_item(CMD_ALLOC, '0, REGION_W'($urandom), FIRST_W'($urandom),
                         RUN_W'($urandom));
            2: send_item(CMD_RELEASE, BYTE_W'({$urandom, $urandom}), REGION_W'($urandom),
                         FIRST_W'($urandom), RUN_W'($urandom));
            default: send_item(cmd_type'($urandom_range(0, 3)),
                               BYTE_W'({$urandom, $urandom}), REGION_W'($urandom),
                               FIRST_W'($urandom), RUN_W'($urandom));
         endcase
      end
   endtask

   initial begin : result_sink
      alloc_result_t got;
      int unsigned   stall_left;
      stall_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_valid && !rsp_stall) begin
            got.status       = status_type'(rsp_status);
            got.region       = rsp_granted_region;
            got.first        = rsp_granted_first;
            got.frames       = rsp_granted_frames;
            got.free_frames  = rsp_free_frames;
            got.total_frames = rsp_total_frames;
            got.allocated    = rsp_allocated_count;
            got.exhausted    = rsp_exhausted_count;
            got.grown        = rsp_grown_count;
            got.direct       = rsp_direct_count;
            got.copied       = rsp_copied_count;
            ledger.check_response(got);
         end
         if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) rsp_stall <= 1'b0;
         end else if (hold_rsp) begin
            hold_rsp   = 1'b0;
            stall_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17);
            rsp_stall <= 1'b1;
         end
         @(posedge clock);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      ledger = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run at the reset register values.
      send_item(CMD_DIRECT, '0, '0, '0, '0);
      send_item(CMD_COPIED, '1, '1, '1, '1);
      send_item(CMD_ALLOC, '0, '0, '0, '0);
      send_item(CMD_ALLOC, BYTE_W'(1), '0, '0, '0);
      send_item(CMD_ALLOC, '1, '0, '0, '0);
      send_item(CMD_ALLOC, BYTE_W'(65 << 20), '0, '0, '0);
      send_item(CMD_ALLOC, BYTE_W'(64 << 20), '0, '0, '0);
      send_item(CMD_ALLOC, BYTE_W'((1 << 20) + 1), '0, '0, '0);
      send_item(CMD_RELEASE, '0, REGION_W'(5), '0, RUN_W'(64));
      send_item(CMD_RELEASE, '0, REGION_W'(1), FIRST_W'(60), RUN_W'(127));
      send_item(CMD_RELEASE, '0, REGION_W'(1), FIRST_W'(60), RUN_W'(4));
      send_item(CMD_RELEASE, '0, '0, '0, '0);
      send_item(CMD_RELEASE, '0, '0, '0, RUN_W'(1));
      send_item(CMD_ALLOC, BYTE_W'(1 << 20), '0, '0, '0);
      send_item(CMD_ALLOC, BYTE_W'(4 << 20), '0, '0, '0);
      send_item(CMD_RELEASE, '0, REGION_W'(7), FIRST_W'(63), RUN_W'(1));
      send_item(CMD_RELEASE, '0, REGION_W'(1), FIRST_W'(63), RUN_W'(64));
      drain_results();

      for (int p = 0; p < NUM_PHASES; p++) begin
         apply_config(PHASE_SHIFT[p], PHASE_LIMIT[p]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 1 && k == PHASE_ITEMS / 3) hold_rsp = 1'b1;
            if (p == 3 && k == PHASE_ITEMS / 2) drain_results();
            random_item();
         end
         drain_results();
      end

      // Closing stretch runs at full rate on both sides.
      idle_on = 1'b0;
      apply_config($urandom_range(0, 31), $urandom_range(0, 15));
      for (int k = 0; k < LAST_ITEMS; k++) random_item();
      drain_results();

      $display("Run covered %0d requests under %0d register settings: %0d grants, %0d exhausted,",
               sent, settings, ledger.n_alloc, ledger.n_exhaust);
      $display("%0d zero-byte requests, %0d releases and %0d regions in use; %0d results checked.",
               ledger.seen_zero, ledger.seen_release, ledger.regions, ledger.checked);
      if (ledger.mismatches == 0 && ledger.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
